FILE: rtl/core/kcs_pkg.sv
package kcs_pkg;

    // look-back span in bytes, current byte included (16 to 32)
    localparam int WINDOW_BYTES = 16;
    localparam int HIST_DEPTH   = WINDOW_BYTES - 1;

    localparam int KW_COUNT  = 9;
    localparam int KW_MAXLEN = 16;
    localparam int KW_LEN_W  = $clog2(KW_MAXLEN + 1);

    typedef logic [7:0]                   byte_t;
    typedef logic [KW_MAXLEN*8-1:0]       kw_text_t;
    typedef logic [KW_LEN_W-1:0]          kw_len_t;
    typedef logic [1:0]                   kw_cat_t;
    typedef logic [KW_MAXLEN-1:0][7:0]    match_win_t;

    typedef struct packed {
        logic hijack;
        logic escalation;
        logic exfil;
    } cat_flags_t;

    localparam kw_cat_t CAT_HIJACK     = 2'd0;
    localparam kw_cat_t CAT_ESCALATION = 2'd1;
    localparam kw_cat_t CAT_EXFIL      = 2'd2;

    // string literals are right aligned: byte i from the lsb is the char
    // that must sit i positions back from the newest byte
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        kw_text_t'("ignore previous"),
        kw_text_t'("override"),
        kw_text_t'("system prompt"),
        kw_text_t'("escalat"),
        kw_text_t'("sudo"),
        kw_text_t'("admin"),
        kw_text_t'("exfiltrat"),
        kw_text_t'("send to external"),
        kw_text_t'("api key")
    };

    localparam kw_len_t KW_LEN [KW_COUNT] = '{
        kw_len_t'(15), kw_len_t'(8), kw_len_t'(13),
        kw_len_t'(7),  kw_len_t'(4), kw_len_t'(5),
        kw_len_t'(9),  kw_len_t'(16), kw_len_t'(7)
    };

    localparam kw_cat_t KW_CAT [KW_COUNT] = '{
        CAT_HIJACK, CAT_HIJACK, CAT_HIJACK,
        CAT_ESCALATION, CAT_ESCALATION, CAT_ESCALATION,
        CAT_EXFIL, CAT_EXFIL, CAT_EXFIL
    };

    typedef logic [1:0] verdict_t;
    localparam verdict_t VERDICT_SAFE       = 2'd0;
    localparam verdict_t VERDICT_SUSPICIOUS = 2'd1;
    localparam verdict_t VERDICT_BLOCKED    = 2'd2;

    typedef logic [6:0] conf_t;
    localparam conf_t CONF_SAFE       = 7'd100;
    localparam conf_t CONF_SUSPICIOUS = 7'd70;
    localparam conf_t CONF_BLOCKED    = 7'd95;

    localparam byte_t CASE_FOLD_OFFSET = 8'h20;

    // ascii upper case to lower case, everything else untouched
    function automatic byte_t fold_byte(input byte_t b);
        byte_t r;
        r = b;
        if (b inside {[8'h41:8'h5A]})
        begin
            r = b + CASE_FOLD_OFFSET;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/kcs_match.sv
module kcs_match
    import kcs_pkg::*;
(
    input  match_win_t win,
    output cat_flags_t cat_hit
);

    logic [KW_COUNT-1:0] kw_hit;

    // one comparator row per keyword, all in parallel
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_hit[k] = 1'b1;
            for (int i = 0; i < KW_MAXLEN; i++)
            begin
                if ((kw_len_t'(i) < KW_LEN[k]) &&
                    (fold_byte(win[i]) != KW_TEXT[k][i*8 +: 8]))
                begin
                    kw_hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        cat_hit = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (kw_hit[k])
            begin
                case (KW_CAT[k])
                    CAT_HIJACK:     cat_hit.hijack     = 1'b1;
                    CAT_ESCALATION: cat_hit.escalation = 1'b1;
                    CAT_EXFIL:      cat_hit.exfil      = 1'b1;
                    default:        cat_hit.exfil      = 1'b1;
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/keyword_category_scanner_core.sv
// Keyword category scanner: one text byte per input transaction, last_byte
// marks the end of a message. Every byte is checked against nine fixed
// keywords (ascii letters case-folded) ending at that byte, using the byte
// itself and the previous bytes held in a shift window; hits set sticky
// category flags. The transaction carrying last_byte gives exactly one
// result transaction (flags, verdict, confidence) and clears the window and
// flags, so keywords never span messages. Throughput is one byte per clock
// while in_ready is high: the window, the flags and the result register are
// all registered, and results appear in the cycle after the last byte is
// taken. A non-last byte is accepted even while a result waits; a last byte
// waits only while the result register is still full and not being taken.
module keyword_category_scanner_core
    import kcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       goal_hijack,
    output logic       privilege_escalation,
    output logic       data_exfiltration,
    output logic [1:0] verdict,
    output logic [6:0] confidence_pct
);

    // history of previous bytes, [0] is the newest
    byte_t      hist_reg [HIST_DEPTH];
    cat_flags_t flags_reg;
    cat_flags_t flags_next;
    cat_flags_t cat_hit;
    match_win_t win;

    // result register
    logic       out_valid_reg;
    cat_flags_t res_flags_reg;
    verdict_t   verdict_reg;
    verdict_t   verdict_next;
    conf_t      conf_reg;
    conf_t      conf_next;
    logic [1:0] cat_count;

    logic in_fire;
    logic out_fire;
    logic res_load;

    // only a last byte needs room in the result register
    assign in_ready = !last_byte || !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign res_load = in_fire && last_byte;

    // match window: current byte plus the newest history bytes
    always_comb
    begin
        win[0] = text_byte;
        for (int i = 1; i < KW_MAXLEN; i++)
        begin
            win[i] = hist_reg[i-1];
        end
    end

    kcs_match u_match (
        .win     (win),
        .cat_hit (cat_hit)
    );

    assign flags_next = flags_reg | cat_hit;

    assign cat_count = {1'b0, flags_next.hijack} + {1'b0, flags_next.escalation}
                     + {1'b0, flags_next.exfil};

    always_comb
    begin
        case (cat_count)
            2'd0:
            begin
                verdict_next = VERDICT_SAFE;
                conf_next    = CONF_SAFE;
            end
            2'd1:
            begin
                verdict_next = VERDICT_SUSPICIOUS;
                conf_next    = CONF_SUSPICIOUS;
            end
            default:
            begin
                verdict_next = VERDICT_BLOCKED;
                conf_next    = CONF_BLOCKED;
            end
        endcase
    end

    // window and sticky flags; both clear at message end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            flags_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_byte)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= '0;
                end
                flags_reg <= '0;
            end
            else
            begin
                hist_reg[0] <= text_byte;
                for (int i = 1; i < HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_flags_reg <= flags_next;
            verdict_reg   <= verdict_next;
            conf_reg      <= conf_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign goal_hijack          = res_flags_reg.hijack;
    assign privilege_escalation = res_flags_reg.escalation;
    assign data_exfiltration    = res_flags_reg.exfil;
    assign verdict              = verdict_reg;
    assign confidence_pct       = conf_reg;

    // a taken last byte always leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid_reg)
        else $error("last byte accepted but no result pending");

    // flags are cleared after a message ends
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (flags_reg == '0))
        else $error("category flags not cleared at message end");

    // verdict agrees with the reported categories
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((verdict_reg == VERDICT_SAFE) == (res_flags_reg == '0)))
        else $error("verdict inconsistent with category flags");

    // confidence follows the verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((verdict_reg == VERDICT_SAFE && conf_reg == CONF_SAFE) ||
                           (verdict_reg == VERDICT_SUSPICIOUS &&
                            conf_reg == CONF_SUSPICIOUS) ||
                           (verdict_reg == VERDICT_BLOCKED && conf_reg == CONF_BLOCKED)))
        else $error("confidence does not match verdict");

endmodule
